FILE: rtl/core/tvl_pkg.sv
// ----------------------------------------------------------------------------
// tvl_pkg: shared types and constants for the terrain vertex light builder
// Holds the configuration register map, field widths and the stage-load
// control group that the top level hands to each datapath lane.
// ----------------------------------------------------------------------------
package tvl_pkg;

    // Configuration port geometry: six registers at 8-byte spacing.
    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned REG_IDX_W  = 3;

    // Register indexes, taken from paddr[5:3].
    localparam logic [REG_IDX_W-1:0] REG_AXIS_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_Z = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AMB    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BIAS   = 3'd5;

    // Field widths.
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned PACK_W   = 48;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FRAC_W   = 8;

    // Intermediate widths: 16-bit signed times 9-bit signed (zero-extended byte).
    localparam int unsigned PROD_W   = 25;
    localparam int unsigned PSUM_W   = 33;
    localparam int unsigned LSUM_W   = 27;

    // Light byte ceiling.
    localparam logic [BYTE_W-1:0] LIGHT_MAX = 8'hFF;

    // Per-stage load strobes shared by every lane.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_ld;

endpackage

FILE: rtl/core/tvl_pos_lane.sv
// ----------------------------------------------------------------------------
// tvl_pos_lane: one axis of the vertex position
// Forms axis * height + base over three register stages and saturates the
// sum to the signed 32-bit range.
// ----------------------------------------------------------------------------
module tvl_pos_lane (
    input  logic                                 i_clk,
    input  tvl_pkg::t_stage_ld                   i_ld,
    input  logic signed [tvl_pkg::COEF_W-1:0]    i_axis,
    input  logic        [tvl_pkg::BYTE_W-1:0]    i_height,
    input  logic signed [tvl_pkg::POS_W-1:0]     i_base,
    output logic signed [tvl_pkg::POS_W-1:0]     o_pos
);

    logic signed [tvl_pkg::PROD_W-1:0] n_prod;
    logic signed [tvl_pkg::PROD_W-1:0] r_prod;
    logic signed [tvl_pkg::POS_W-1:0]  r_base;
    logic signed [tvl_pkg::PSUM_W-1:0] n_sum;
    logic signed [tvl_pkg::PSUM_W-1:0] r_sum;
    logic signed [tvl_pkg::POS_W-1:0]  n_pos;
    logic signed [tvl_pkg::POS_W-1:0]  r_pos;

    // Stage one: the height is an unsigned byte, so it enters as a positive value.
    assign n_prod = tvl_pkg::PROD_W'(i_axis) * tvl_pkg::PROD_W'($signed({1'b0, i_height}));

    // Stage two: full-width sum, which cannot overflow 33 bits.
    assign n_sum = tvl_pkg::PSUM_W'(r_prod) + tvl_pkg::PSUM_W'(r_base);

    // Stage three: saturate when the two top bits disagree.
    always_comb begin
        if (r_sum[tvl_pkg::PSUM_W-1] == r_sum[tvl_pkg::PSUM_W-2]) begin
            n_pos = r_sum[tvl_pkg::POS_W-1:0];
        end else if (r_sum[tvl_pkg::PSUM_W-1]) begin
            n_pos = {1'b1, {(tvl_pkg::POS_W-1){1'b0}}};
        end else begin
            n_pos = {1'b0, {(tvl_pkg::POS_W-1){1'b1}}};
        end
    end

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_prod <= n_prod;
            r_base <= i_base;
        end
        if (i_ld.ld2) begin
            r_sum <= n_sum;
        end
        if (i_ld.ld3) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

FILE: rtl/core/tvl_light_lane.sv
// ----------------------------------------------------------------------------
// tvl_light_lane: one colour channel of the vertex light
// Forms scale * level + ambient (+ shadow bias), truncates toward zero and
// reduces the result to a byte, clamping large values to full brightness.
// ----------------------------------------------------------------------------
module tvl_light_lane (
    input  logic                                 i_clk,
    input  tvl_pkg::t_stage_ld                   i_ld,
    input  logic signed [tvl_pkg::COEF_W-1:0]    i_scale,
    input  logic signed [tvl_pkg::COEF_W-1:0]    i_ambient,
    input  logic signed [tvl_pkg::COEF_W-1:0]    i_bias,
    input  logic        [tvl_pkg::BYTE_W-1:0]    i_level,
    input  logic                                 i_shadow,
    output logic        [tvl_pkg::BYTE_W-1:0]    o_byte
);

    localparam int unsigned INT_W = tvl_pkg::LSUM_W - tvl_pkg::FRAC_W;

    logic signed [tvl_pkg::PROD_W-1:0] n_prod;
    logic signed [tvl_pkg::PROD_W-1:0] r_prod;
    logic                              r_shadow;
    logic signed [tvl_pkg::LSUM_W-1:0] n_sum;
    logic signed [tvl_pkg::LSUM_W-1:0] r_sum;
    logic signed [INT_W-1:0]           w_int;
    logic                              w_round_up;
    logic        [tvl_pkg::BYTE_W-1:0] n_byte;
    logic        [tvl_pkg::BYTE_W-1:0] r_byte;

    // Stage one: the level is never negative.
    assign n_prod = tvl_pkg::PROD_W'(i_scale) * tvl_pkg::PROD_W'($signed({1'b0, i_level}));

    // Stage two: add the ambient term and, for shadowed vertices, the bias.
    assign n_sum = tvl_pkg::LSUM_W'(r_prod) + tvl_pkg::LSUM_W'(i_ambient)
                 + (r_shadow ? tvl_pkg::LSUM_W'(i_bias) : '0);

    // Stage three: an arithmetic shift floors, so a negative sum with a
    // nonzero fraction is nudged up by one to truncate toward zero.
    assign w_round_up = r_sum[tvl_pkg::LSUM_W-1] && (r_sum[tvl_pkg::FRAC_W-1:0] != '0);
    assign w_int      = r_sum[tvl_pkg::LSUM_W-1:tvl_pkg::FRAC_W]
                      + INT_W'(w_round_up);

    // Values above 255 clamp; anything else keeps its low byte, so negatives wrap.
    always_comb begin
        if (!w_int[INT_W-1] && (w_int[INT_W-2:tvl_pkg::BYTE_W] != '0)) begin
            n_byte = tvl_pkg::LIGHT_MAX;
        end else begin
            n_byte = w_int[tvl_pkg::BYTE_W-1:0];
        end
    end

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_prod   <= n_prod;
            r_shadow <= i_shadow;
        end
        if (i_ld.ld2) begin
            r_sum <= n_sum;
        end
        if (i_ld.ld3) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

FILE: rtl/core/terrain_vertex_light_build.sv
// ----------------------------------------------------------------------------
// terrain_vertex_light_build: terrain vertex position and light builder
// Three-stage pipeline with a valid/ready stream on each side and a 64-bit
// APB-style register port for the height axis and the light coefficients.
// ----------------------------------------------------------------------------
// The block takes one vertex per clock cycle while the output side is not
// stalled. The three register stages are the multiply (axis by height,
// scale by level), the wide add, and the saturate / clamp into the output
// register. Each stage keeps its own valid bit and advances whenever the
// stage after it is empty or moving, so bubbles are squeezed out during a
// stall and nothing is lost or repeated. Registers sit at byte addresses
// 0x00, 0x08 .. 0x28 and should be written only while no vertex is in flight.
module terrain_vertex_light_build (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tvl_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [tvl_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [tvl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    // Vertex input stream
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic        [tvl_pkg::BYTE_W-1:0]    i_height_sample,
    input  logic        [tvl_pkg::BYTE_W-1:0]    i_type_byte,
    input  logic signed [tvl_pkg::POS_W-1:0]     i_base_x,
    input  logic signed [tvl_pkg::POS_W-1:0]     i_base_y,
    input  logic signed [tvl_pkg::POS_W-1:0]     i_base_z,
    // Vertex result stream
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [tvl_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [tvl_pkg::POS_W-1:0]     o_pos_y,
    output logic signed [tvl_pkg::POS_W-1:0]     o_pos_z,
    output logic        [tvl_pkg::BYTE_W-1:0]    o_red,
    output logic        [tvl_pkg::BYTE_W-1:0]    o_green,
    output logic        [tvl_pkg::BYTE_W-1:0]    o_blue,
    output logic        [3*tvl_pkg::BYTE_W-1:0]  o_packed_color
);

    logic [tvl_pkg::COEF_W-1:0]    r_axis_x;
    logic [tvl_pkg::COEF_W-1:0]    r_axis_y;
    logic [tvl_pkg::COEF_W-1:0]    r_axis_z;
    logic [tvl_pkg::PACK_W-1:0]    r_scale;
    logic [tvl_pkg::PACK_W-1:0]    r_amb;
    logic [tvl_pkg::PACK_W-1:0]    r_bias;
    logic [tvl_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                          w_wr;

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic                          w_rdy1;
    logic                          w_rdy2;
    logic                          w_rdy3;
    tvl_pkg::t_stage_ld            w_ld;
    logic [tvl_pkg::BYTE_W-1:0]    w_level;

    // Register write decode: a write completes in the access phase.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[tvl_pkg::APB_ADDR_W-1:tvl_pkg::APB_ADDR_W-tvl_pkg::REG_IDX_W];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_x <= '0;
            r_axis_y <= '0;
            r_axis_z <= '0;
            r_scale  <= '0;
            r_amb    <= '0;
            r_bias   <= '0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                tvl_pkg::REG_AXIS_X: r_axis_x <= pwdata[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_AXIS_Y: r_axis_y <= pwdata[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_AXIS_Z: r_axis_z <= pwdata[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_SCALE:  r_scale  <= pwdata[tvl_pkg::PACK_W-1:0];
                tvl_pkg::REG_AMB:    r_amb    <= pwdata[tvl_pkg::PACK_W-1:0];
                tvl_pkg::REG_BIAS:   r_bias   <= pwdata[tvl_pkg::PACK_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            tvl_pkg::REG_AXIS_X: prdata = tvl_pkg::APB_DATA_W'(r_axis_x);
            tvl_pkg::REG_AXIS_Y: prdata = tvl_pkg::APB_DATA_W'(r_axis_y);
            tvl_pkg::REG_AXIS_Z: prdata = tvl_pkg::APB_DATA_W'(r_axis_z);
            tvl_pkg::REG_SCALE:  prdata = tvl_pkg::APB_DATA_W'(r_scale);
            tvl_pkg::REG_AMB:    prdata = tvl_pkg::APB_DATA_W'(r_amb);
            tvl_pkg::REG_BIAS:   prdata = tvl_pkg::APB_DATA_W'(r_bias);
            default:             prdata = '0;
        endcase
    end

    // Pipeline flow: a stage may load when it is empty or its contents move on.
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;

    assign w_ld.ld1 = w_rdy1;
    assign w_ld.ld2 = w_rdy2;
    assign w_ld.ld3 = w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Light level is the low seven type bits doubled.
    assign w_level = {i_type_byte[tvl_pkg::BYTE_W-2:0], 1'b0};

    // Position lanes.
    tvl_pos_lane u_pos_x (
        .i_clk    (i_clk),
        .i_ld     (w_ld),
        .i_axis   ($signed(r_axis_x)),
        .i_height (i_height_sample),
        .i_base   (i_base_x),
        .o_pos    (o_pos_x)
    );

    tvl_pos_lane u_pos_y (
        .i_clk    (i_clk),
        .i_ld     (w_ld),
        .i_axis   ($signed(r_axis_y)),
        .i_height (i_height_sample),
        .i_base   (i_base_y),
        .o_pos    (o_pos_y)
    );

    tvl_pos_lane u_pos_z (
        .i_clk    (i_clk),
        .i_ld     (w_ld),
        .i_axis   ($signed(r_axis_z)),
        .i_height (i_height_sample),
        .i_base   (i_base_z),
        .o_pos    (o_pos_z)
    );

    // Light lanes: red in the top slice of each packed register, blue at the bottom.
    tvl_light_lane u_light_r (
        .i_clk     (i_clk),
        .i_ld      (w_ld),
        .i_scale   ($signed(r_scale[47:32])),
        .i_ambient ($signed(r_amb[47:32])),
        .i_bias    ($signed(r_bias[47:32])),
        .i_level   (w_level),
        .i_shadow  (i_type_byte[tvl_pkg::BYTE_W-1]),
        .o_byte    (o_red)
    );

    tvl_light_lane u_light_g (
        .i_clk     (i_clk),
        .i_ld      (w_ld),
        .i_scale   ($signed(r_scale[31:16])),
        .i_ambient ($signed(r_amb[31:16])),
        .i_bias    ($signed(r_bias[31:16])),
        .i_level   (w_level),
        .i_shadow  (i_type_byte[tvl_pkg::BYTE_W-1]),
        .o_byte    (o_green)
    );

    tvl_light_lane u_light_b (
        .i_clk     (i_clk),
        .i_ld      (w_ld),
        .i_scale   ($signed(r_scale[15:0])),
        .i_ambient ($signed(r_amb[15:0])),
        .i_bias    ($signed(r_bias[15:0])),
        .i_level   (w_level),
        .i_shadow  (i_type_byte[tvl_pkg::BYTE_W-1]),
        .o_byte    (o_blue)
    );

    assign o_packed_color = {o_red, o_green, o_blue};

    // An empty output stage never holds back the input side.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output stage is empty");

    // With every stage full, input readiness follows the output side exactly.
    a_full_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3) |-> (o_ready == i_ready))
        else $error("full pipeline readiness mismatch");

    // A transfer in with no stall downstream moves through every stage to the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_ready) ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("vertex did not reach the output in three cycles");

endmodule

FILE: sim/tb_terrain_vertex_light_build.sv
// ----------------------------------------------------------------------------
// tb_terrain_vertex_light_build: self-checking bench for the vertex builder
// Programs the height axis and light coefficients over the register port,
// streams vertices with random gaps and output stalls, and compares every
// result transfer field by field against a predicted vertex.
// ----------------------------------------------------------------------------
module tb_terrain_vertex_light_build;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int GAP_PCT     = 16;

    // Lane positions inside the packed colour registers.
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    // Addresses past the last register; writes there must change nothing.
    localparam logic [tvl_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tvl_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint POS_HI = 2147483647;
    localparam longint POS_LO = -POS_HI - 1;

    localparam logic signed [tvl_pkg::POS_W-1:0] BASE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [tvl_pkg::POS_W-1:0] BASE_MIN = 32'sh8000_0000;

    typedef struct {
        logic        [tvl_pkg::BYTE_W-1:0] height;
        logic        [tvl_pkg::BYTE_W-1:0] kind;
        logic signed [tvl_pkg::POS_W-1:0]  base_x;
        logic signed [tvl_pkg::POS_W-1:0]  base_y;
        logic signed [tvl_pkg::POS_W-1:0]  base_z;
    } t_vertex_in;

    typedef struct {
        logic signed [tvl_pkg::POS_W-1:0]    pos_x;
        logic signed [tvl_pkg::POS_W-1:0]    pos_y;
        logic signed [tvl_pkg::POS_W-1:0]    pos_z;
        logic        [tvl_pkg::BYTE_W-1:0]   red;
        logic        [tvl_pkg::BYTE_W-1:0]   green;
        logic        [tvl_pkg::BYTE_W-1:0]   blue;
        logic        [3*tvl_pkg::BYTE_W-1:0] colour;
    } t_vertex_out;

    // Holds a mirror of the registers and the vertices still owed by the block.
    class vertex_book;
        logic signed [tvl_pkg::COEF_W-1:0] axis_x      = '0;
        logic signed [tvl_pkg::COEF_W-1:0] axis_y      = '0;
        logic signed [tvl_pkg::COEF_W-1:0] axis_z      = '0;
        logic        [tvl_pkg::PACK_W-1:0] scale_rgb   = '0;
        logic        [tvl_pkg::PACK_W-1:0] ambient_rgb = '0;
        logic        [tvl_pkg::PACK_W-1:0] bias_rgb    = '0;
        t_vertex_out                       pending_vertices[$];
        int unsigned                       fails = 0;

        function void write_reg(logic [tvl_pkg::REG_IDX_W-1:0] idx,
                                logic [tvl_pkg::APB_DATA_W-1:0] data);
            case (idx)
                tvl_pkg::REG_AXIS_X: axis_x      = data[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_AXIS_Y: axis_y      = data[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_AXIS_Z: axis_z      = data[tvl_pkg::COEF_W-1:0];
                tvl_pkg::REG_SCALE:  scale_rgb   = data[tvl_pkg::PACK_W-1:0];
                tvl_pkg::REG_AMB:    ambient_rgb = data[tvl_pkg::PACK_W-1:0];
                tvl_pkg::REG_BIAS:   bias_rgb    = data[tvl_pkg::PACK_W-1:0];
                default: ;
            endcase
        endfunction

        function longint lane(logic [tvl_pkg::PACK_W-1:0] word, int ch);
            logic signed [tvl_pkg::COEF_W-1:0] v;
            v = word[tvl_pkg::COEF_W*ch +: tvl_pkg::COEF_W];
            return v;
        endfunction

        // Axis times height plus base, clipped to the 32-bit signed range.
        function logic signed [tvl_pkg::POS_W-1:0] place(
                logic signed [tvl_pkg::COEF_W-1:0] ax,
                logic [tvl_pkg::BYTE_W-1:0] h,
                logic signed [tvl_pkg::POS_W-1:0] base);
            longint s;
            s = longint'(ax) * longint'(h) + longint'(base);
            if (s > POS_HI)
                s = POS_HI;
            else if (s < POS_LO)
                s = POS_LO;
            return s[tvl_pkg::POS_W-1:0];
        endfunction

        // Q8.8 channel sum, truncated toward zero; only the top end clamps.
        function logic [tvl_pkg::BYTE_W-1:0] channel_byte(int ch, longint level, bit shade);
            longint s;
            longint t;
            s = lane(scale_rgb, ch) * level + lane(ambient_rgb, ch);
            if (shade)
                s += lane(bias_rgb, ch);
            t = s / 256;
            if (t > 255)
                return tvl_pkg::LIGHT_MAX;
            return t[tvl_pkg::BYTE_W-1:0];
        endfunction

        function t_vertex_out build_vertex(t_vertex_in v);
            t_vertex_out o;
            longint      level;
            level    = longint'(v.kind[6:0]) * 2;
            o.pos_x  = place(axis_x, v.height, v.base_x);
            o.pos_y  = place(axis_y, v.height, v.base_y);
            o.pos_z  = place(axis_z, v.height, v.base_z);
            o.red    = channel_byte(CH_R, level, v.kind[7]);
            o.green  = channel_byte(CH_G, level, v.kind[7]);
            o.blue   = channel_byte(CH_B, level, v.kind[7]);
            o.colour = {o.red, o.green, o.blue};
            return o;
        endfunction

        function void note_vertex(t_vertex_in v);
            pending_vertices.push_back(build_vertex(v));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_vertex(t_vertex_out got);
            t_vertex_out want;
            if (pending_vertices.size() == 0) begin
                $error("result transfer with no vertex outstanding");
                fails++;
                return;
            end
            want = pending_vertices.pop_front();
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("pos_z", want.pos_z, got.pos_z);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("packed_color", want.colour, got.colour);
        endfunction

        function int pending();
            return pending_vertices.size();
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [tvl_pkg::APB_ADDR_W-1:0]       paddr = '0;
    logic [tvl_pkg::APB_DATA_W-1:0]       pwdata = '0;
    logic [tvl_pkg::APB_DATA_W-1:0]       prdata;
    logic                                 pready;
    logic                                 i_valid = 1'b0;
    logic                                 o_ready;
    logic        [tvl_pkg::BYTE_W-1:0]    i_height_sample = '0;
    logic        [tvl_pkg::BYTE_W-1:0]    i_type_byte = '0;
    logic signed [tvl_pkg::POS_W-1:0]     i_base_x = '0;
    logic signed [tvl_pkg::POS_W-1:0]     i_base_y = '0;
    logic signed [tvl_pkg::POS_W-1:0]     i_base_z = '0;
    logic                                 o_valid;
    logic                                 i_ready = 1'b0;
    logic signed [tvl_pkg::POS_W-1:0]     o_pos_x;
    logic signed [tvl_pkg::POS_W-1:0]     o_pos_y;
    logic signed [tvl_pkg::POS_W-1:0]     o_pos_z;
    logic        [tvl_pkg::BYTE_W-1:0]    o_red;
    logic        [tvl_pkg::BYTE_W-1:0]    o_green;
    logic        [tvl_pkg::BYTE_W-1:0]    o_blue;
    logic        [3*tvl_pkg::BYTE_W-1:0]  o_packed_color;

    // Traffic shaping flags set by the stimulus.
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    bit hold_request = 1'b0;

    vertex_book book;

    terrain_vertex_light_build u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_height_sample(i_height_sample),
        .i_type_byte    (i_type_byte),
        .i_base_x       (i_base_x),
        .i_base_y       (i_base_y),
        .i_base_z       (i_base_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_packed_color (o_packed_color)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Runaway guard.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("terrain_vertex_light_build verification failed");
        $finish;
    end

    // Record every accepted vertex transfer.
    always @(posedge i_clk) begin : watch_input
        t_vertex_in seen;
        if (i_rst_n && i_valid && o_ready) begin
            seen.height = i_height_sample;
            seen.kind   = i_type_byte;
            seen.base_x = i_base_x;
            seen.base_y = i_base_y;
            seen.base_z = i_base_z;
            book.note_vertex(seen);
        end
    end

    // Check every accepted result transfer.
    always @(posedge i_clk) begin : watch_output
        t_vertex_out got;
        if (i_rst_n && o_valid && i_ready) begin
            got.pos_x  = o_pos_x;
            got.pos_y  = o_pos_y;
            got.pos_z  = o_pos_z;
            got.red    = o_red;
            got.green  = o_green;
            got.blue   = o_blue;
            got.colour = o_packed_color;
            book.check_vertex(got);
        end
    end

    // Output side: random stalls, steady stretches and one long hold-off.
    initial begin : result_sink
        int hold_count;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_count++;
                end
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= GAP_PCT);
            end
        end
    end

    function automatic t_vertex_in make_vertex(logic [tvl_pkg::BYTE_W-1:0] h,
                                               logic [tvl_pkg::BYTE_W-1:0] k,
                                               logic signed [tvl_pkg::POS_W-1:0] x,
                                               logic signed [tvl_pkg::POS_W-1:0] y,
                                               logic signed [tvl_pkg::POS_W-1:0] z);
        t_vertex_in v;
        v.height = h;
        v.kind   = k;
        v.base_x = x;
        v.base_y = y;
        v.base_z = z;
        return v;
    endfunction

    // Bases cluster near the limits now and then so that saturation is hit.
    function automatic logic signed [tvl_pkg::POS_W-1:0] random_base();
        case ($urandom_range(0, 9))
            0: return BASE_MAX - $urandom_range(0, 65535);
            1: return BASE_MIN + $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vertex_in random_vertex();
        return make_vertex(tvl_pkg::BYTE_W'($urandom), tvl_pkg::BYTE_W'($urandom),
                           random_base(), random_base(), random_base());
    endfunction

    // Tame coefficients keep the light sums near the byte range.
    function automatic logic [tvl_pkg::COEF_W-1:0] random_coef(bit tame);
        int v;
        if (!tame)
            return tvl_pkg::COEF_W'($urandom);
        v = $urandom_range(0, 768) - 384;
        return v[tvl_pkg::COEF_W-1:0];
    endfunction

    function automatic logic [tvl_pkg::PACK_W-1:0] random_lanes(bit tame);
        return {random_coef(tame), random_coef(tame), random_coef(tame)};
    endfunction

    // Offer one vertex and hold it until the transfer happens.
    task automatic drive_vertex(t_vertex_in v);
        i_valid         <= 1'b1;
        i_height_sample <= v.height;
        i_type_byte     <= v.kind;
        i_base_x        <= v.base_x;
        i_base_y        <= v.base_y;
        i_base_z        <= v.base_z;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // Now and then the sender leaves one cycle empty.
    task automatic idle_input();
        if (!tx_steady && $urandom_range(0, 99) < GAP_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Setup cycle, then access cycle; the register is written when pready is seen.
    task automatic write_reg(logic [tvl_pkg::REG_IDX_W-1:0] idx,
                             logic [tvl_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // Writes every register with junk above its width, plus the spare slots.
    task automatic load_config(logic [tvl_pkg::COEF_W-1:0] ax, logic [tvl_pkg::COEF_W-1:0] ay,
                               logic [tvl_pkg::COEF_W-1:0] az,
                               logic [tvl_pkg::PACK_W-1:0] scale,
                               logic [tvl_pkg::PACK_W-1:0] amb,
                               logic [tvl_pkg::PACK_W-1:0] bias);
        logic [tvl_pkg::APB_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(tvl_pkg::REG_AXIS_X, {junk[63:16], ax});
        write_reg(tvl_pkg::REG_AXIS_Y, {~junk[63:16], ay});
        write_reg(tvl_pkg::REG_AXIS_Z, {junk[63:16], az});
        write_reg(tvl_pkg::REG_SCALE, {junk[63:48], scale});
        write_reg(tvl_pkg::REG_AMB, {~junk[63:48], amb});
        write_reg(tvl_pkg::REG_BIAS, {junk[63:48], bias});
        write_reg(REG_SPARE_LO, junk);
        write_reg(REG_SPARE_HI, ~junk);
    endtask

    // Stop offering and wait for the pipeline to empty completely.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase;
        bit tame;
        book = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With reset coefficients every vertex is its base and black.
        drive_vertex(make_vertex(8'd255, 8'hFF, BASE_MAX, BASE_MIN, 32'sd0));
        drive_vertex(make_vertex(8'd0, 8'h80, -32'sd1, 32'sd1, BASE_MAX));
        drive_vertex(make_vertex(8'd128, 8'h7F, BASE_MIN, BASE_MAX, -32'sd1));
        wait_for_results();

        // Axis extremes drive saturation; light lanes cover clamp, wrap and
        // sub-unit fractions in both signs.
        load_config(16'h7FFF, 16'h8000, 16'h0100,
                    {16'h7FFF, 16'h8000, 16'h0080},
                    {16'h0000, 16'h00FF, 16'hFF01},
                    {16'h8000, 16'h7FFF, 16'hFF00});
        drive_vertex(make_vertex(8'd255, 8'hFF, BASE_MAX, BASE_MIN, 32'sd0));
        idle_input();
        drive_vertex(make_vertex(8'd255, 8'h7F, BASE_MAX, BASE_MIN, -32'sd1));
        drive_vertex(make_vertex(8'd0, 8'h00, BASE_MIN, BASE_MAX, 32'sd0));
        drive_vertex(make_vertex(8'd0, 8'h80, 32'sd0, 32'sd0, 32'sd0));
        idle_input();
        drive_vertex(make_vertex(8'd1, 8'h01, -32'sd1, -32'sd1, -32'sd1));
        drive_vertex(make_vertex(8'd1, 8'h81, BASE_MAX, BASE_MAX, BASE_MAX));
        drive_vertex(make_vertex(8'd128, 8'h81, BASE_MIN, BASE_MIN, BASE_MIN));
        idle_input();
        drive_vertex(make_vertex(8'd255, 8'hFE, BASE_MIN, BASE_MAX, 32'sh7FFF_0000));
        drive_vertex(make_vertex(8'd255, 8'h00, 32'sd0, 32'sd0, 32'sd0));
        drive_vertex(make_vertex(8'd200, 8'hC0, 32'sh0000_FF00, -32'sh0001_0000, 32'sd256));
        drive_vertex(make_vertex(8'd77, 8'h40, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0));
        idle_input();
        drive_vertex(make_vertex(8'd170, 8'h2A, 32'shAAAA_AAAA, 32'sh5555_5555, BASE_MAX));
        drive_vertex(make_vertex(8'd85, 8'hD5, BASE_MAX, BASE_MIN, BASE_MIN));
        wait_for_results();

        // Every coefficient at its positive, then its negative limit.
        load_config(16'h7FFF, 16'h7FFF, 16'h7FFF, {3{16'h7FFF}}, {3{16'h7FFF}},
                    {3{16'h7FFF}});
        repeat (30) begin
            idle_input();
            drive_vertex(random_vertex());
        end
        wait_for_results();
        load_config(16'h8000, 16'h8000, 16'h8000, {3{16'h8000}}, {3{16'h8000}},
                    {3{16'h8000}});
        repeat (30) begin
            idle_input();
            drive_vertex(random_vertex());
        end
        wait_for_results();

        // Random coefficient sets; one phase runs without gaps on either side,
        // another holds the output off while vertices keep coming.
        for (phase = 0; phase < 7; phase++) begin
            tame = phase[0];
            load_config(random_coef(tame), random_coef(tame), random_coef(tame),
                        random_lanes(tame), random_lanes(tame), random_lanes(tame));
            tx_steady = (phase == 2) || (phase == 4);
            rx_steady = (phase == 2);
            if (phase == 4)
                hold_request = 1'b1;
            repeat (45) begin
                idle_input();
                drive_vertex(random_vertex());
            end
            wait_for_results();
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        if (book.fails == 0 && book.pending() == 0)
            $display("terrain_vertex_light_build verification clean");
        else
            $display("terrain_vertex_light_build verification failed");
        $finish;
    end

endmodule

FILE: terrain_vertex_light_build.f
rtl/core/tvl_pkg.sv
rtl/core/tvl_pos_lane.sv
rtl/core/tvl_light_lane.sv
rtl/core/terrain_vertex_light_build.sv
sim/tb_terrain_vertex_light_build.sv
